### rtl/tlpq_pkg.sv
// Shared types and codes of the three-level priority queue.
`timescale 1ns / 1ps

package tlpq_pkg;

  localparam int TAG_W  = 16;
  localparam int LVL_W  = 2;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCEL = 2'd2;

  localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [TAG_W-1:0] payload;
    logic [LVL_W-1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  out_payload;
    logic [LVL_W-1:0]  out_priority;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_ACCEL,
    ST_DONE
  } state_t;

endpackage

### rtl/tlpq_store.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module tlpq_store #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  tlpq_pkg::entry_t          wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output tlpq_pkg::entry_t          rd_data
);

  tlpq_pkg::entry_t mem [DEPTH];
  tlpq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tlpq_seq.sv
// Sequencer: walks the store one entry a cycle for scan, shift and accelerate.
`timescale 1ns / 1ps

module tlpq_seq #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  tlpq_pkg::in_req_t         req,
  output logic                      req_ready,
  output logic                      res_valid,
  input  logic                      res_ready,
  output tlpq_pkg::result_t         res,
  output logic                      wr_en,
  output logic [$clog2(DEPTH)-1:0]  wr_addr,
  output tlpq_pkg::entry_t          wr_data,
  output logic                      rd_en,
  output logic [$clog2(DEPTH)-1:0]  rd_addr,
  input  tlpq_pkg::entry_t          rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tlpq_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          rv_r, rv_nxt;
  logic [AW-1:0]                 ra_r, ra_nxt;
  logic [AW-1:0]                 best_r, best_nxt;
  logic [tlpq_pkg::LVL_W-1:0]    best_lvl_r, best_lvl_nxt;
  logic [tlpq_pkg::TAG_W-1:0]    best_tag_r, best_tag_nxt;
  logic [tlpq_pkg::STAT_W-1:0]   status_r, status_nxt;

  logic                          walk_done;
  logic                          take_new;
  logic [tlpq_pkg::LVL_W-1:0]    put_lvl;

  assign walk_done = (idx_r == cnt_r);
  // the scan's level comparator: first entry, or strictly higher level
  assign take_new  = rv_r && ((ra_r == '0) || (rd_data.lvl > best_lvl_r));
  assign put_lvl   = (req.priority_req > tlpq_pkg::LVL_HIGH) ? tlpq_pkg::LVL_HIGH
                                                             : req.priority_req;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlpq_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req.op)
            tlpq_pkg::OP_GET:   state_nxt = (cnt_r == '0) ? tlpq_pkg::ST_DONE
                                                          : tlpq_pkg::ST_SCAN;
            tlpq_pkg::OP_ACCEL: state_nxt = tlpq_pkg::ST_ACCEL;
            default:            state_nxt = tlpq_pkg::ST_DONE;
          endcase
        end
      end
      tlpq_pkg::ST_SCAN: begin
        if (walk_done) state_nxt = tlpq_pkg::ST_SHIFT;
      end
      tlpq_pkg::ST_SHIFT: begin
        if (walk_done) state_nxt = tlpq_pkg::ST_DONE;
      end
      tlpq_pkg::ST_ACCEL: begin
        if (walk_done) state_nxt = tlpq_pkg::ST_DONE;
      end
      tlpq_pkg::ST_DONE: begin
        if (res_ready) state_nxt = tlpq_pkg::ST_IDLE;
      end
      default: state_nxt = tlpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    rv_nxt       = 1'b0;
    ra_nxt       = ra_r;
    best_nxt     = best_r;
    best_lvl_nxt = best_lvl_r;
    best_tag_nxt = best_tag_r;
    status_nxt   = status_r;
    wr_en        = 1'b0;
    wr_addr      = ra_r;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = idx_r[AW-1:0];

    // issue one read a cycle while walking
    if ((state_r == tlpq_pkg::ST_SCAN || state_r == tlpq_pkg::ST_SHIFT ||
         state_r == tlpq_pkg::ST_ACCEL) && !walk_done) begin
      rd_en   = 1'b1;
      idx_nxt = idx_r + CW'(1);
      rv_nxt  = 1'b1;
      ra_nxt  = idx_r[AW-1:0];
    end

    case (state_r)
      tlpq_pkg::ST_IDLE: begin
        if (req_valid) begin
          status_nxt   = tlpq_pkg::STATUS_OK;
          best_tag_nxt = '0;
          best_lvl_nxt = tlpq_pkg::LVL_LOW;
          best_nxt     = '0;
          idx_nxt      = '0;
          case (req.op)
            tlpq_pkg::OP_PUT: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = tlpq_pkg::STATUS_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = cnt_r[AW-1:0];
                wr_data.tag = req.payload;
                wr_data.lvl = put_lvl;
                cnt_nxt     = cnt_r + CW'(1);
              end
            end
            tlpq_pkg::OP_GET: begin
              if (cnt_r == '0) status_nxt = tlpq_pkg::STATUS_EMPTY;
            end
            default: ;
          endcase
        end
      end
      tlpq_pkg::ST_SCAN: begin
        if (take_new) begin
          best_nxt     = ra_r;
          best_lvl_nxt = rd_data.lvl;
          best_tag_nxt = rd_data.tag;
        end
        // start the gap close just past the winner
        if (walk_done) begin
          idx_nxt = CW'(best_nxt) + CW'(1);
        end
      end
      tlpq_pkg::ST_SHIFT: begin
        if (rv_r) begin
          wr_en   = 1'b1;
          wr_addr = ra_r - AW'(1);
        end
        if (walk_done) cnt_nxt = cnt_r - CW'(1);
      end
      tlpq_pkg::ST_ACCEL: begin
        if (rv_r && rd_data.lvl == tlpq_pkg::LVL_LOW) begin
          wr_en       = 1'b1;
          wr_addr     = ra_r;
          wr_data.lvl = tlpq_pkg::LVL_HIGH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlpq_pkg::ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r       <= ra_nxt;
    best_r     <= best_nxt;
    best_lvl_r <= best_lvl_nxt;
    best_tag_r <= best_tag_nxt;
    status_r   <= status_nxt;
  end

  assign req_ready        = (state_r == tlpq_pkg::ST_IDLE);
  assign res_valid        = (state_r == tlpq_pkg::ST_DONE);
  assign res.out_payload  = best_tag_r;
  assign res.out_priority = best_lvl_r;
  assign res.status       = status_r;
  assign res.fill_count   = tlpq_pkg::FILL_W'(cnt_r);

endmodule

### rtl/three_level_priority_queue_top.sv
// Top level of the three-level priority queue.
`timescale 1ns / 1ps

//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+---------------------------
//  input   | in_valid, in_stall, in_req     | in        | request: op, tag, level
//  result  | out_valid, out_stall, out_res  | out       | result of each request
//
//  A put, an empty get and an unused op go from accept straight to done.
//  An accelerate walks all N entries held; a get walks all N to find the
//  entry to remove, then walks the entries behind it to close the gap. Each
//  walk through the store moves one entry a cycle.
//  One request is in work at a time; in_stall stays high until its result
//  moves into the output register. Reset is synchronous and empties the
//  queue; stored entries need no clearing. A stalled result holds while the
//  next request is already accepted and worked on.

module three_level_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpq_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpq_pkg::result_t   out_res
);

  localparam int AW = $clog2(DEPTH);

  logic               seq_ready;
  logic               res_valid;
  logic               res_ready;
  tlpq_pkg::result_t  res;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  tlpq_pkg::entry_t   wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  tlpq_pkg::entry_t   rd_data;

  logic               out_valid_r;
  tlpq_pkg::result_t  out_res_r;

  // sequencer takes a request only when idle
  assign in_stall  = !seq_ready;
  // the output slot frees when empty or when its result leaves this cycle
  assign res_ready = !out_valid_r || !out_stall;

  tlpq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (in_req),
    .req_ready (seq_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tlpq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/tlpq_checker.sv
// Port checker for the three-level priority queue, bound to the top level.
`timescale 1ns / 1ps

module tlpq_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tlpq_pkg::result_t  out_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // failed requests carry no entry
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != tlpq_pkg::STATUS_OK |->
      out_res.out_payload == '0 && out_res.out_priority == tlpq_pkg::LVL_LOW)
    else $error("failed request returned an entry");

  // a full store reports its depth; an empty get reports zero
  a_fill_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_res.status != tlpq_pkg::STATUS_FULL ||
       out_res.fill_count == tlpq_pkg::FILL_W'(DEPTH)) &&
      (out_res.status != tlpq_pkg::STATUS_EMPTY || out_res.fill_count == '0))
    else $error("fill count inconsistent with status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind three_level_priority_queue_top tlpq_checker #(
  .DEPTH (DEPTH)
) u_tlpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

### verif/tb.sv
// Self-checking testbench for the three-level priority queue.
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH = 16;
  // Worst request is a get on a full queue, which walks the store twice. Allow the
  // slowest stall and idle mix on every request, then several times more.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP = 30;

  // Codes outside the defined set; the block must still handle them.
  localparam logic [tlpq_pkg::OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [tlpq_pkg::LVL_W-1:0] LVL_OVER  = 2'd3;

  // Golden model of the queue plus the in-order store of predicted results.
  class queue_scoreboard;
    tlpq_pkg::entry_t  held[$];
    tlpq_pkg::result_t awaited[$];
    int      mismatches = 0;
    int      checked = 0;

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_CAP)
        $display("tb: mismatch on %s at result %0d: got %0h, want %0h (t=%0t)",
                 what, checked, got, want, $realtime);
      mismatches++;
    endtask

    // Apply one accepted request to the model and queue its result.
    function void note_request(tlpq_pkg::in_req_t req);
      tlpq_pkg::result_t want;
      tlpq_pkg::entry_t  ent;
      int      best;
      want = '0;
      case (req.op)
        tlpq_pkg::OP_PUT: begin
          if (held.size() >= QUEUE_DEPTH) begin
            want.status = tlpq_pkg::STATUS_FULL;
          end else begin
            ent.tag = req.payload;
            ent.lvl = (req.priority_req > tlpq_pkg::LVL_HIGH) ? tlpq_pkg::LVL_HIGH
                                                              : req.priority_req;
            held = {held, ent};
          end
        end
        tlpq_pkg::OP_GET: begin
          if (held.size() == 0) begin
            want.status = tlpq_pkg::STATUS_EMPTY;
          end else begin
            // Strict compare keeps the oldest entry of the top level.
            best = 0;
            for (int i = 1; i < held.size(); i++)
              if (held[i].lvl > held[best].lvl) best = i;
            want.out_payload  = held[best].tag;
            want.out_priority = held[best].lvl;
            held.delete(best);
          end
        end
        tlpq_pkg::OP_ACCEL: begin
          foreach (held[i])
            if (held[i].lvl == tlpq_pkg::LVL_LOW) held[i].lvl = tlpq_pkg::LVL_HIGH;
        end
        default: ;
      endcase
      want.fill_count = tlpq_pkg::FILL_W'(held.size());
      awaited = {awaited, want};
    endfunction

    task check_result(tlpq_pkg::result_t got);
      tlpq_pkg::result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(got), '0);
        return;
      end
      want = awaited.pop_front();
      if (got.out_payload !== want.out_payload)
        report_mismatch("out_payload", 32'(got.out_payload), 32'(want.out_payload));
      if (got.out_priority !== want.out_priority)
        report_mismatch("out_priority", 32'(got.out_priority),
                        32'(want.out_priority));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.fill_count !== want.fill_count)
        report_mismatch("fill_count", 32'(got.fill_count), 32'(want.fill_count));
      checked++;
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  tlpq_pkg::in_req_t in_req;
  logic    out_valid;
  logic    out_stall;
  tlpq_pkg::result_t out_res;

  queue_scoreboard board = new;

  int  send_idle_pct;    // chance per cycle that the sender holds off
  int  recv_stall_pct;   // chance per cycle that the receiver stalls
  int  plan_fill;        // fill level as the stimulus side tracks it
  bit  draining;         // random part: favor gets over puts
  int  op_count[4];
  int  cycle_count = 0;

  three_level_priority_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  // 10 ns clock, first rising edge at 5 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side: draw a fresh stall decision every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitors: sample at the edge, before any of this step's updates land.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_request(in_req);
    if (rst_n && out_valid && !out_stall) board.check_result(out_res);
  end

  // Present one request, optionally after an idle gap, and hold it until
  // the block takes it. Valid is lowered only when a gap is inserted, so it
  // never sees two updates in one time step.
  task automatic send_request(input tlpq_pkg::in_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Build a request, track the expected fill level and send it.
  task automatic issue(input logic [tlpq_pkg::OP_W-1:0] op,
                       input logic [tlpq_pkg::TAG_W-1:0] tag,
                       input logic [tlpq_pkg::LVL_W-1:0] lvl);
    tlpq_pkg::in_req_t req;
    req.op = op;
    req.payload = tag;
    req.priority_req = lvl;
    op_count[op]++;
    if (op == tlpq_pkg::OP_PUT && plan_fill < QUEUE_DEPTH) plan_fill++;
    if (op == tlpq_pkg::OP_GET && plan_fill > 0) plan_fill--;
    send_request(req);
  endtask

  // Random traffic that swings between filling and draining the queue, so
  // full and empty are both hit often and scans run over varied depths.
  task automatic run_random(input int count);
    logic [tlpq_pkg::OP_W-1:0] op;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (plan_fill == QUEUE_DEPTH && $urandom_range(1) == 1) draining = 1'b1;
      else if (plan_fill == 0 && $urandom_range(1) == 1) draining = 1'b0;
      else if ($urandom_range(29) == 0) draining = !draining;
      if (!draining)
        op = (pick < 60) ? tlpq_pkg::OP_PUT : (pick < 82) ? tlpq_pkg::OP_GET :
             (pick < 95) ? tlpq_pkg::OP_ACCEL : OP_UNUSED;
      else
        op = (pick < 20) ? tlpq_pkg::OP_PUT : (pick < 82) ? tlpq_pkg::OP_GET :
             (pick < 95) ? tlpq_pkg::OP_ACCEL : OP_UNUSED;
      issue(op, tlpq_pkg::TAG_W'($urandom), tlpq_pkg::LVL_W'($urandom_range(3)));
    end
  endtask

  logic [tlpq_pkg::LVL_W-1:0] lvl_pattern [4];

  initial begin
    lvl_pattern = '{tlpq_pkg::LVL_LOW, tlpq_pkg::LVL_NORMAL, tlpq_pkg::LVL_HIGH,
                    LVL_OVER};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    plan_fill = 0;
    draining = 1'b0;
    send_idle_pct = 26;
    recv_stall_pct = 83;

    // Hold reset, then release it once for the whole run.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-queue cases first.
    issue(tlpq_pkg::OP_GET, 16'hFFFF, tlpq_pkg::LVL_HIGH);
    issue(tlpq_pkg::OP_ACCEL, 16'hA5A5, LVL_OVER);

    // Fill to capacity, cycling every level code (3 must saturate to high)
    // and covering all-zero and all-one tags.
    for (int i = 0; i < QUEUE_DEPTH; i++)
      issue(tlpq_pkg::OP_PUT, (i == 0) ? 16'h0000 : tlpq_pkg::TAG_W'(i * 16'h1111),
            lvl_pattern[i % 4]);

    // Full-queue cases, then promote the lows and pull a few back out.
    issue(tlpq_pkg::OP_PUT, 16'h5555, tlpq_pkg::LVL_HIGH);
    issue(OP_UNUSED, 16'hAAAA, tlpq_pkg::LVL_NORMAL);
    issue(tlpq_pkg::OP_ACCEL, 16'h0000, tlpq_pkg::LVL_LOW);
    repeat (4) issue(tlpq_pkg::OP_GET, tlpq_pkg::TAG_W'($urandom),
                     tlpq_pkg::LVL_W'($urandom_range(3)));

    // Random: slow receiver, then slow sender, then back to back.
    run_random(175);
    send_idle_pct = 83;
    recv_stall_pct = 26;
    run_random(175);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(175);
    in_valid <= 1'b0;

    // Wait for every predicted result, then watch for stray ones.
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests: %0d put, %0d get, %0d accelerate, %0d unused op",
             op_count[tlpq_pkg::OP_PUT] + op_count[tlpq_pkg::OP_GET] +
             op_count[tlpq_pkg::OP_ACCEL] + op_count[OP_UNUSED],
             op_count[tlpq_pkg::OP_PUT], op_count[tlpq_pkg::OP_GET],
             op_count[tlpq_pkg::OP_ACCEL], op_count[OP_UNUSED]);
    $display("tb: %0d results compared, %0d mismatches", board.checked,
             board.mismatches);
    if (board.mismatches == 0 && board.awaited.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
